// File: src/lkvc_pkg.sv
package lkvc_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam logic [4:0]  CAP_RESET  = 5'd16;
    localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } rsp_t;

endpackage

// File: src/lkvc_req_reg.sv
module lkvc_req_reg
    import lkvc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  logic drain,
    input  req_t req_in,
    output logic req_valid,
    output req_t req_out
);

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    assign valid_next = load | (valid_reg & ~drain);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req_in;
        end
    end

    assign req_valid = valid_reg;
    assign req_out   = req_reg;

endmodule

// File: src/lkvc_store.sv
module lkvc_store
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_data,
    input  logic       fire,
    input  req_t       req,
    output rsp_t       rsp
);

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);

    logic signed [31:0] key_reg   [ENTRIES];
    logic signed [31:0] value_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [RW-1:0]      rank_reg  [ENTRIES];
    logic [RW-1:0]      rank_next [ENTRIES];
    logic [OW-1:0]      occ_reg;
    logic [OW-1:0]      occ_next;
    logic [4:0]         cap_reg;

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic               match_any;
    logic [RW-1:0]      match_idx;
    logic [RW-1:0]      victim_idx;
    logic [RW-1:0]      free_idx;
    logic [RW-1:0]      slot_idx;
    logic [RW-1:0]      hit_rank;
    logic [RW-1:0]      occ_m1;
    logic [7:0]         cap8;
    logic [7:0]         ent8;
    logic [7:0]         cap_eff8;
    logic               is_put;
    logic               insert;
    logic               evict;

    assign is_put = (req.req_type == REQ_PUT);
    assign occ_m1 = RW'(occ_reg - OW'(1));

    always_comb
    begin
        match_vec  = '0;
        victim_vec = '0;
        match_any  = 1'b0;
        match_idx  = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i]  = valid_reg[i] && (key_reg[i] == req.key);
            victim_vec[i] = valid_reg[i] && (rank_reg[i] == occ_m1);
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_any = 1'b1;
                match_idx = RW'(i);
            end
            if (victim_vec[i])
            begin
                victim_idx = RW'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = RW'(i);
            end
        end
    end

    // capacity clamped to 1..ENTRIES
    assign cap8     = {3'b000, cap_reg};
    assign ent8     = 8'(ENTRIES);
    assign cap_eff8 = (cap8 == 8'd0) ? 8'd1 : ((cap8 > ent8) ? ent8 : cap8);

    assign insert   = is_put && !match_any;
    assign evict    = insert && (8'(occ_reg) >= cap_eff8);
    assign slot_idx = evict ? victim_idx : free_idx;
    assign hit_rank = rank_reg[match_idx];

    always_comb
    begin
        rsp.hit         = match_any;
        rsp.evicted     = evict;
        rsp.evicted_key = evict ? key_reg[victim_idx] : 32'sd0;
        if (is_put)
        begin
            rsp.read_value = 32'sd0;
        end
        else if (match_any)
        begin
            rsp.read_value = value_reg[match_idx];
        end
        else
        begin
            rsp.read_value = MISS_VALUE;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (match_any)
            begin
                if (RW'(i) == match_idx)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
            else if (is_put)
            begin
                if (RW'(i) == slot_idx)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
        end
        if (insert)
        begin
            valid_next[slot_idx] = 1'b1;
            if (!evict)
            begin
                occ_next = occ_reg + OW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (fire)
            begin
                valid_reg <= valid_next;
                occ_reg   <= occ_next;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    rank_reg[i] <= rank_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && insert)
        begin
            key_reg[slot_idx]   <= req.key;
            value_reg[slot_idx] <= req.value;
        end
        else if (fire && match_any && is_put)
        begin
            value_reg[match_idx] <= req.value;
        end
    end

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy out of step with valid entries");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(ENTRIES))
        else $error("occupancy above entry count");

    a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("key held in more than one entry");

    a_victim_unique: assert property (@(posedge clk) disable iff (!rst_n)
        fire && evict |-> $onehot(victim_vec) && !match_any)
        else $error("no single least recent entry at eviction");

endmodule

// File: src/lkvc_rsp_reg.sv
module lkvc_rsp_reg
    import lkvc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  logic take,
    input  rsp_t rsp_in,
    output logic rsp_valid,
    output rsp_t rsp_out
);

    logic valid_reg;
    logic valid_next;
    rsp_t rsp_reg;

    assign valid_next = load | (valid_reg & ~take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_in;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_out   = rsp_reg;

endmodule

// File: src/lru_key_value_cache_top.sv
// Fully associative key/value cache with least-recently-used replacement. Each request
// (get or put of a 32-bit key) gives exactly one result: hit flag, read value (-1 on a get
// miss, 0 for a put) and the evicted key when a put of a new key finds the cache full.
// The cache accepts one request per cycle while out_ready stays high. The result is
// registered: the request register holds the request while the parallel key compare and
// rank update run, and the result register is loaded when the request moves on. A result
// held by out_ready low stalls the request register and then in_ready. The capacity
// register (1..ENTRIES, 0 acts as 1, larger values as ENTRIES) must be written through the
// cfg channel only while idle; the block itself does not enforce this.
module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic signed [31:0] key,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic signed [31:0] read_value,
    output logic               evicted,
    output logic signed [31:0] evicted_key
);

    req_t req_in;
    req_t req_q;
    rsp_t rsp_d;
    rsp_t rsp_q;
    logic req_valid;
    logic fire;
    logic in_xfer;

    assign req_in.req_type = req_type;
    assign req_in.key      = key;
    assign req_in.value    = value;

    // request moves on when the result slot is free or being drained
    assign fire      = req_valid && (!out_valid || out_ready);
    assign in_ready  = !req_valid || fire;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    lkvc_req_reg u_req_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_xfer),
        .drain     (fire),
        .req_in    (req_in),
        .req_valid (req_valid),
        .req_out   (req_q)
    );

    lkvc_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .fire     (fire),
        .req      (req_q),
        .rsp      (rsp_d)
    );

    lkvc_rsp_reg u_rsp_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .take      (out_ready),
        .rsp_in    (rsp_d),
        .rsp_valid (out_valid),
        .rsp_out   (rsp_q)
    );

    assign hit         = rsp_q.hit;
    assign read_value  = rsp_q.read_value;
    assign evicted     = rsp_q.evicted;
    assign evicted_key = rsp_q.evicted_key;

endmodule

// File: tb/lru_key_value_cache_checker.sv
`timescale 1ns / 1ps

module lru_key_value_cache_checker
    import lkvc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               req_type,
    input  logic signed [31:0] key,
    input  logic signed [31:0] value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               hit,
    input  logic signed [31:0] read_value,
    input  logic               evicted,
    input  logic signed [31:0] evicted_key,
    output int                 outstanding,
    output int                 mismatches
);

    localparam int LINES = ENTRIES_DEF;
    localparam int DEPTH = 16;

    logic [31:0] line_key   [LINES];
    logic [31:0] line_data  [LINES];
    logic        line_valid [LINES];
    logic [3:0]  line_age   [LINES];
    logic [4:0]  lines_used;
    logic [4:0]  capacity;
    rsp_t        expected_buf [DEPTH];
    int          rd_ptr;
    int          wr_ptr;
    int          pending;

    function automatic void promote(int s);
        logic [3:0] old_age;
        int i;
        old_age = line_age[s];
        for (i = 0; i < LINES; i++)
        begin
            if (line_valid[i] && i != s && line_age[i] < old_age)
                line_age[i] = line_age[i] + 4'd1;
        end
        line_age[s] = 4'd0;
    endfunction

    function automatic rsp_t cache_access(logic op, logic [31:0] k, logic [31:0] v);
        rsp_t       r;
        int         found;
        int         slot;
        int         i;
        logic [4:0] limit;
        logic [3:0] oldest;
        r = '0;
        found = -1;
        slot = -1;
        oldest = 4'd0;
        limit = (capacity == 5'd0) ? 5'd1 : (capacity > LINES) ? 5'(LINES) : capacity;
        for (i = 0; i < LINES; i++)
        begin
            if (found < 0 && line_valid[i] && line_key[i] == k)
                found = i;
        end
        if (op == REQ_GET)
        begin
            if (found >= 0)
            begin
                r.hit = 1'b1;
                r.read_value = line_data[found];
                promote(found);
            end
            else
                r.read_value = MISS_VALUE;
        end
        else if (found >= 0)
        begin
            r.hit = 1'b1;
            line_data[found] = v;
            promote(found);
        end
        else
        begin
            if (lines_used >= limit && lines_used > 5'd0)
            begin
                for (i = 0; i < LINES; i++)
                begin
                    if (line_valid[i] && (slot < 0 || line_age[i] > oldest))
                    begin
                        slot = i;
                        oldest = line_age[i];
                    end
                end
                r.evicted = 1'b1;
                r.evicted_key = line_key[slot];
                line_valid[slot] = 1'b0;
                lines_used = lines_used - 5'd1;
            end
            if (slot < 0)
            begin
                for (i = LINES - 1; i >= 0; i--)
                begin
                    if (!line_valid[i])
                        slot = i;
                end
            end
            for (i = 0; i < LINES; i++)
            begin
                if (line_valid[i])
                    line_age[i] = line_age[i] + 4'd1;
            end
            line_key[slot] = k;
            line_data[slot] = v;
            line_valid[slot] = 1'b1;
            line_age[slot] = 4'd0;
            lines_used = lines_used + 5'd1;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < LINES; i++)
            begin
                line_key[i] = '0;
                line_data[i] = '0;
                line_valid[i] = 1'b0;
                line_age[i] = '0;
            end
            lines_used = '0;
            capacity = CAP_RESET;
            rd_ptr = 0;
            wr_ptr = 0;
            pending = 0;
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (out_valid && out_ready)
            begin
                if (pending == 0)
                begin
                    $display("%0t: unexpected result hit %0b read_value %h evicted %0b key %h",
                             $time, hit, read_value, evicted, evicted_key);
                    mismatches++;
                end
                else
                begin
                    want = expected_buf[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    pending--;
                    check_field("hit", 32'(want.hit), 32'(hit));
                    check_field("read_value", want.read_value, read_value);
                    check_field("evicted", 32'(want.evicted), 32'(evicted));
                    check_field("evicted_key", want.evicted_key, evicted_key);
                end
            end
            if (in_valid && in_ready)
            begin
                if (pending == DEPTH)
                begin
                    $display("%0t: more than %0d transfers in flight", $time, DEPTH);
                    mismatches++;
                end
                else
                begin
                    expected_buf[wr_ptr] = cache_access(req_type, key, value);
                    wr_ptr = (wr_ptr + 1) % DEPTH;
                    pending++;
                end
            end
            outstanding <= pending;
        end
    end

endmodule

// File: tb/lru_key_value_cache_top_tb.sv
`timescale 1ns / 1ps

module lru_key_value_cache_top_tb
    import lkvc_pkg::*;
();

    localparam int LIMIT       = 1_000_000;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 100;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [4:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               req_type;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_ready;
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
    int                 outstanding;
    int                 mismatches;
    bit                 steady;

    lru_key_value_cache_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    lru_key_value_cache_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int idle_cycles();
        int pick;
        if (steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic op, input logic [31:0] k, input logic [31:0] v);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        key <= k;
        value <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [4:0] c);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_cycles();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [31:0] key_pool [24];
        logic [4:0]  cap_sel;
        logic        op;
        logic [31:0] k;
        int          pool_size;
        int          eff;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = REQ_GET;
        key = '0;
        value = '0;
        steady = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(REQ_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_PUT, 32'h7FFF_FFFF, 32'h5A5A_A5A5);
        send_request(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(REQ_GET, 32'h1234_5678, 32'h0000_0000);
        // zero acts as one, and four lines are already in use
        write_capacity(5'd0);
        send_request(REQ_PUT, 32'h0000_0001, 32'h1111_1111);
        send_request(REQ_PUT, 32'h0000_0002, 32'h2222_2222);
        send_request(REQ_PUT, 32'h0000_0002, 32'h3333_3333);
        send_request(REQ_GET, 32'h0000_0001, 32'h0000_0000);
        send_request(REQ_GET, 32'h0000_0002, 32'h0000_0000);
        write_capacity(5'd1);
        send_request(REQ_PUT, 32'h0000_0003, 32'h4444_4444);
        send_request(REQ_GET, 32'h0000_0002, 32'h0000_0000);
        // above the number of lines saturates
        write_capacity(5'd31);
        send_request(REQ_PUT, 32'h0000_0004, 32'h5555_5555);
        send_request(REQ_PUT, 32'h0000_0005, 32'h6666_6666);
        send_request(REQ_GET, 32'h0000_0003, 32'h0000_0000);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       cap_sel = 5'd31;
                1:       cap_sel = 5'd1;
                2:       cap_sel = 5'd16;
                3:       cap_sel = 5'd0;
                4:       cap_sel = 5'd2;
                5:       cap_sel = 5'd15;
                default: cap_sel = 5'($urandom_range(0, 31));
            endcase
            write_capacity(cap_sel);
            steady = (phase % 4 == 3);
            eff = (cap_sel == 5'd0) ? 1 : (cap_sel > 5'd16) ? 16 : int'(cap_sel);
            pool_size = eff + $urandom_range(1, 8);
            for (int j = 0; j < pool_size; j++)
            begin
                case ($urandom_range(0, 11))
                    0:       key_pool[j] = 32'h8000_0000;
                    1:       key_pool[j] = 32'h7FFF_FFFF;
                    2:       key_pool[j] = 32'h0000_0000;
                    default: key_pool[j] = $urandom;
                endcase
            end
            repeat (PHASE_ITEMS)
            begin
                op = ($urandom_range(0, 99) < 55) ? REQ_PUT : REQ_GET;
                if ($urandom_range(0, 9) == 0)
                    k = $urandom;
                else
                    k = key_pool[$urandom_range(0, pool_size - 1)];
                send_request(op, k, $urandom);
            end
        end

        in_valid <= 1'b0;
        steady = 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
